// ===== rtl/core/multiplexed_display_scanner_macros.svh =====
// ----------------------------------------------------------------------------
// display scanner assertion macros
// shared property shapes for the scanner checkers
// ----------------------------------------------------------------------------
`ifndef MULTIPLEXED_DISPLAY_SCANNER_MACROS_SVH
`define MULTIPLEXED_DISPLAY_SCANNER_MACROS_SVH

// condition holds in the same cycle
`define MDS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition holds in the next cycle
`define MDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/mds_pkg.sv =====
// ----------------------------------------------------------------------------
// display scanner package
// types, codes and constants shared by the scanner files
// ----------------------------------------------------------------------------
package mds_pkg;

	localparam int DIGITS_DEF        = 8;
	localparam int CLOCK_FREQ_HZ_DEF = 20000000;
	localparam int TIMER_DIVISOR_DEF = 16;
	localparam int BLANK_TICKS_DEF   = 250;

	localparam int MAX_DIGITS = 8;
	localparam int POS_W      = 3;
	localparam int BYTE_W     = 8;
	localparam int COUNT_W    = 16;
	localparam int RAM_DEPTH  = 2 * MAX_DIGITS;

	localparam logic [COUNT_W-1:0] PERIOD_MIN_US   = 16'd1000;
	localparam logic [COUNT_W-1:0] PERIOD_MAX_US   = 16'd50000;
	localparam logic [COUNT_W-1:0] PERIOD_RESET_US = 16'd2000;
	localparam logic [BYTE_W-1:0]  SELECT_TOP      = 8'h80;

	// x / 1000 computed as (x >> 3) / 125 by reciprocal multiply
	localparam int               DIV_PRESHIFT = 3;
	localparam logic [29:0]      RECIP_125    = 30'd549755814;
	localparam int               RECIP_SHIFT  = 36;

	// cycles for the period pipeline to follow a register change
	localparam logic [1:0] SETTLE_CYCLES = 2'd3;

	// buffer select in the upper address bit
	localparam logic BANK_PENDING = 1'b0;
	localparam logic BANK_SHOWN   = 1'b1;

	typedef enum logic [1:0] {
		ACT_SEGMENTS   = 2'd0,
		ACT_BRIGHTNESS = 2'd1,
		ACT_COMMIT     = 2'd2,
		ACT_ADVANCE    = 2'd3
	} action_t;

	typedef struct packed {
		action_t           action;
		logic [POS_W-1:0]  digit_index;
		logic [BYTE_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  digit_select;
		logic [BYTE_W-1:0]  segment_bits;
		logic [COUNT_W-1:0] period_count;
		logic [COUNT_W-1:0] on_count;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADV_READ,
		ST_ADV_MUL,
		ST_ADV_OUT,
		ST_COMMIT,
		ST_COMMIT_LAST
	} state_t;

endpackage

// ===== rtl/core/mds_ram.sv =====
// ----------------------------------------------------------------------------
// generic ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module mds_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== rtl/core/multiplexed_display_scanner.sv =====
// ----------------------------------------------------------------------------
// multiplexed display scanner
// double-buffered seven-segment scan driver with pwm on-count
// ----------------------------------------------------------------------------
// An advance passes through the ram read, multiply and output load states; the
// output load waits while an earlier result is still stalled, and the block
// takes the next item only after that load. A commit copies the pending buffer
// to the shown buffer one digit per cycle through the ram ports. After reset
// and after every register write the period pipeline (two multipliers) must
// settle before items are taken again.
// All buffers read as zero until written; no clearing pass is run.
module multiplexed_display_scanner #(
	parameter int DIGITS        = mds_pkg::DIGITS_DEF,
	parameter int CLOCK_FREQ_HZ = mds_pkg::CLOCK_FREQ_HZ_DEF,
	parameter int TIMER_DIVISOR = mds_pkg::TIMER_DIVISOR_DEF,
	parameter int BLANK_TICKS   = mds_pkg::BLANK_TICKS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  mds_pkg::in_item_t               item,
	output logic                            result_valid,
	input  logic                            result_stall,
	output mds_pkg::out_item_t              result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mds_pkg::COUNT_W-1:0]     cfg_data
);

	localparam int PER_MS = (CLOCK_FREQ_HZ / 1000) / TIMER_DIVISOR;
	localparam logic [mds_pkg::COUNT_W-1:0] PER_MS_W = 16'(PER_MS);
	localparam logic [mds_pkg::COUNT_W-1:0] BLANK_W  = 16'(BLANK_TICKS);
	localparam logic [mds_pkg::POS_W-1:0]   LAST_POS = 3'(DIGITS - 1);
	localparam int AW = $clog2(mds_pkg::RAM_DEPTH);

	mds_pkg::state_t state_q, state_d;

	logic [mds_pkg::COUNT_W-1:0] scan_us_q;
	logic [31:0]                 prod_q;
	logic [22:0]                 quot_q;
	logic [58:0]                 recip_prod;
	logic [mds_pkg::COUNT_W-1:0] period_q;
	logic [mds_pkg::COUNT_W-1:0] width_q;
	logic [mds_pkg::COUNT_W-1:0] period_sat;
	logic [1:0]                  settle_q;

	logic [mds_pkg::POS_W-1:0] pos_q;
	logic [mds_pkg::POS_W-1:0] pos_s1;
	logic [mds_pkg::POS_W-1:0] copy_cnt_q;
	logic                      copy_v_s1;
	logic [mds_pkg::POS_W-1:0] copy_idx_s1;

	logic [mds_pkg::MAX_DIGITS-1:0] pend_seg_vld_q, pend_bri_vld_q;
	logic [mds_pkg::MAX_DIGITS-1:0] shown_vld_q;

	logic [mds_pkg::BYTE_W-1:0] seg_s1, bri_s1;
	mds_pkg::out_item_t         res_s2;
	mds_pkg::out_item_t         res_q;
	logic                       res_valid_q;
	logic [23:0]                on_prod;

	logic                       accept;
	logic                       digit_ok;
	logic                       cfg_wr;
	logic                       res_load;
	logic [AW-1:0]              rd_addr;
	logic                       seg_we, bri_we;
	logic [AW-1:0]              wr_addr;
	logic [mds_pkg::BYTE_W-1:0] seg_wdata, bri_wdata;
	logic [mds_pkg::BYTE_W-1:0] seg_rdata, bri_rdata;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;
	assign accept    = item_valid & ~item_stall;
	assign digit_ok  = {1'b0, item.digit_index} < 4'(DIGITS);

	// period pipeline: ticks per ms times us, then divide by 1000
	assign recip_prod = 59'(prod_q[31:mds_pkg::DIV_PRESHIFT]) * 59'(mds_pkg::RECIP_125);
	assign period_sat = (|quot_q[22:16]) ? 16'hFFFF : quot_q[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_us_q <= mds_pkg::PERIOD_RESET_US;
			settle_q  <= mds_pkg::SETTLE_CYCLES;
		end else if (cfg_wr) begin
			if (cfg_data < mds_pkg::PERIOD_MIN_US) begin
				scan_us_q <= mds_pkg::PERIOD_MIN_US;
			end else if (cfg_data > mds_pkg::PERIOD_MAX_US) begin
				scan_us_q <= mds_pkg::PERIOD_MAX_US;
			end else begin
				scan_us_q <= cfg_data;
			end
			settle_q <= mds_pkg::SETTLE_CYCLES;
		end else if (settle_q != 2'd0) begin
			settle_q <= settle_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		prod_q   <= 32'(PER_MS_W) * 32'(scan_us_q);
		quot_q   <= recip_prod[58:mds_pkg::RECIP_SHIFT];
		period_q <= period_sat;
		width_q  <= (period_sat > BLANK_W) ? period_sat - BLANK_W : 16'd0;
	end

	// next state, handshake and ram controls
	always_comb begin
		state_d    = state_q;
		item_stall = (state_q != mds_pkg::ST_IDLE) || (settle_q != 2'd0);
		res_load   = 1'b0;
		rd_addr    = {mds_pkg::BANK_SHOWN, pos_q};
		seg_we     = 1'b0;
		bri_we     = 1'b0;
		wr_addr    = {mds_pkg::BANK_PENDING, item.digit_index};
		seg_wdata  = item.value;
		bri_wdata  = item.value;
		case (state_q)
			mds_pkg::ST_IDLE: begin
				if (accept) begin
					case (item.action)
						mds_pkg::ACT_SEGMENTS:   seg_we = digit_ok;
						mds_pkg::ACT_BRIGHTNESS: bri_we = digit_ok;
						mds_pkg::ACT_COMMIT:     state_d = mds_pkg::ST_COMMIT;
						mds_pkg::ACT_ADVANCE:    state_d = mds_pkg::ST_ADV_READ;
						default:                 state_d = mds_pkg::ST_IDLE;
					endcase
				end
			end
			mds_pkg::ST_ADV_READ: state_d = mds_pkg::ST_ADV_MUL;
			mds_pkg::ST_ADV_MUL:  state_d = mds_pkg::ST_ADV_OUT;
			mds_pkg::ST_ADV_OUT: begin
				if (!res_valid_q || !result_stall) begin
					res_load = 1'b1;
					state_d  = mds_pkg::ST_IDLE;
				end
			end
			mds_pkg::ST_COMMIT: begin
				rd_addr = {mds_pkg::BANK_PENDING, copy_cnt_q};
				if (copy_cnt_q == LAST_POS) begin
					state_d = mds_pkg::ST_COMMIT_LAST;
				end
			end
			mds_pkg::ST_COMMIT_LAST: state_d = mds_pkg::ST_IDLE;
			default:                 state_d = mds_pkg::ST_IDLE;
		endcase
		// copy write follows its read in the next cycle
		if (copy_v_s1) begin
			seg_we    = 1'b1;
			bri_we    = 1'b1;
			wr_addr   = {mds_pkg::BANK_SHOWN, copy_idx_s1};
			seg_wdata = pend_seg_vld_q[copy_idx_s1] ? seg_rdata : 8'd0;
			bri_wdata = pend_bri_vld_q[copy_idx_s1] ? bri_rdata : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= mds_pkg::ST_IDLE;
			pos_q          <= '0;
			copy_cnt_q     <= '0;
			copy_v_s1      <= 1'b0;
			pend_seg_vld_q <= '0;
			pend_bri_vld_q <= '0;
			shown_vld_q    <= '0;
			res_valid_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			copy_v_s1 <= (state_q == mds_pkg::ST_COMMIT);
			if (state_q == mds_pkg::ST_COMMIT) begin
				copy_cnt_q <= copy_cnt_q + 3'd1;
			end else begin
				copy_cnt_q <= '0;
			end
			if (accept && item.action == mds_pkg::ACT_SEGMENTS && digit_ok) begin
				pend_seg_vld_q[item.digit_index] <= 1'b1;
			end
			if (accept && item.action == mds_pkg::ACT_BRIGHTNESS && digit_ok) begin
				pend_bri_vld_q[item.digit_index] <= 1'b1;
			end
			if (copy_v_s1) begin
				shown_vld_q[copy_idx_s1] <= 1'b1;
			end
			if (state_q == mds_pkg::ST_IDLE && accept
					&& item.action == mds_pkg::ACT_ADVANCE) begin
				pos_q <= (pos_q == LAST_POS) ? 3'd0 : pos_q + 3'd1;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign on_prod = 24'(width_q) * 24'(bri_s1);

	always_ff @(posedge clk) begin
		copy_idx_s1 <= copy_cnt_q;
		if (state_q == mds_pkg::ST_IDLE) begin
			pos_s1 <= pos_q;
		end
		if (state_q == mds_pkg::ST_ADV_READ) begin
			seg_s1 <= shown_vld_q[pos_s1] ? seg_rdata : 8'd0;
			bri_s1 <= shown_vld_q[pos_s1] ? bri_rdata : 8'd0;
		end
		if (state_q == mds_pkg::ST_ADV_MUL) begin
			res_s2.digit_select <= mds_pkg::SELECT_TOP >> pos_s1;
			res_s2.segment_bits <= seg_s1;
			res_s2.period_count <= period_q;
			res_s2.on_count     <= on_prod[23:8];
		end
		if (res_load) begin
			res_q <= res_s2;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// lower half pending, upper half shown
	mds_ram #(
		.WIDTH(mds_pkg::BYTE_W),
		.DEPTH(mds_pkg::RAM_DEPTH)
	) u_seg_ram (
		.clk    (clk),
		.wr_en  (seg_we),
		.wr_addr(wr_addr),
		.wr_data(seg_wdata),
		.rd_addr(rd_addr),
		.rd_data(seg_rdata)
	);

	mds_ram #(
		.WIDTH(mds_pkg::BYTE_W),
		.DEPTH(mds_pkg::RAM_DEPTH)
	) u_bri_ram (
		.clk    (clk),
		.wr_en  (bri_we),
		.wr_addr(wr_addr),
		.wr_data(bri_wdata),
		.rd_addr(rd_addr),
		.rd_data(bri_rdata)
	);

endmodule

// ===== rtl/core/mds_checker.sv =====
// ----------------------------------------------------------------------------
// display scanner checker
// port-level properties of the scanner, bound to the top level
// ----------------------------------------------------------------------------
`include "multiplexed_display_scanner_macros.svh"

module mds_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_stall,
	input mds_pkg::in_item_t  item,
	input logic               result_valid,
	input logic               result_stall,
	input mds_pkg::out_item_t result,
	input logic               cfg_valid,
	input logic               cfg_ready
);

	// an offered result is not withdrawn before its transfer
	`MDS_ASSERT_NEXT(a_result_held, clk, arst_n, result_valid && result_stall, result_valid, "result dropped while stalled")

	`MDS_ASSERT_NOW(a_select_onehot, clk, arst_n, result_valid, $onehot(result.digit_select), "digit select not one-hot")

	`MDS_ASSERT_NOW(a_on_within_period, clk, arst_n, result_valid, result.on_count <= result.period_count, "on-count exceeds period")

	// commit sweep blocks the input
	`MDS_ASSERT_NEXT(a_commit_stalls, clk, arst_n, item_valid && !item_stall && item.action == mds_pkg::ACT_COMMIT, item_stall, "item taken during commit")

	// period pipeline settles after a register write
	`MDS_ASSERT_NEXT(a_cfg_settles, clk, arst_n, cfg_valid && cfg_ready, item_stall, "item taken while period settles")

endmodule

bind multiplexed_display_scanner mds_checker u_mds_checker (.*);
